// ===== hdl/lps_pkg.sv =====
// ----------------------------------------------------------------------------
// Line pixel stepper package
// Shared types and fixed field widths for the line rasterizer.
// ----------------------------------------------------------------------------
package lps_pkg;

    // Fixed field widths of the stream payloads and the width register.
    localparam int PIX_BITS    = 12;
    localparam int FW_BITS     = 13;
    localparam int ADDR_BITS   = 24;
    localparam int COLOUR_BITS = 32;

    // Row length after reset.
    localparam logic [FW_BITS-1:0] FW_RESET = 13'd800;

    // Request kinds carried on the input tuser bit.
    localparam logic MODE_START = 1'b0;
    localparam logic MODE_STEP  = 1'b1;

    // How the active line is walked.
    typedef enum logic [1:0] {
        KIND_HORIZ  = 2'd0,
        KIND_VERT   = 2'd1,
        KIND_XMAJOR = 2'd2,
        KIND_YMAJOR = 2'd3
    } line_kind_t;

    // Which pixel of a major position comes next on a sloped line.
    typedef enum logic [1:0] {
        PHASE_MAIN  = 2'd0,
        PHASE_MINOR = 2'd1,
        PHASE_END   = 2'd2
    } phase_t;

endpackage

// ===== hdl/lps_core.sv =====
// ----------------------------------------------------------------------------
// Line stepper core
// Holds the state of the active line and works out, for one request, the
// pixel to emit and the state that follows it.
// ----------------------------------------------------------------------------
module lps_core #(
    parameter int COORD_BITS = 12
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              load,
    input  logic                              mode,
    input  logic [COORD_BITS-1:0]             x1,
    input  logic [COORD_BITS-1:0]             y1,
    input  logic [COORD_BITS-1:0]             x2,
    input  logic [COORD_BITS-1:0]             y2,
    input  logic [lps_pkg::COLOUR_BITS-1:0]   colour,
    output logic                              emit,
    output logic [COORD_BITS-1:0]             pix_x,
    output logic [COORD_BITS-1:0]             pix_y,
    output logic                              pix_last,
    output logic [lps_pkg::COLOUR_BITS-1:0]   pix_colour
);

    localparam int ERR_BITS = COORD_BITS + 1;

    // Line state registers.
    logic                            active_reg;
    lps_pkg::line_kind_t             kind_reg;
    logic [COORD_BITS-1:0]           cur_x_reg;
    logic [COORD_BITS-1:0]           cur_y_reg;
    logic [COORD_BITS-1:0]           stop_x_reg;
    logic [COORD_BITS-1:0]           stop_y_reg;
    logic [COORD_BITS-1:0]           major_reg;
    logic [COORD_BITS-1:0]           minor_reg;
    logic [ERR_BITS-1:0]             err_reg;
    logic                            dir_reg;
    lps_pkg::phase_t                 phase_reg;
    logic [lps_pkg::COLOUR_BITS-1:0] colour_reg;

    // Start decode results.
    logic                            is_start;
    logic [COORD_BITS-1:0]           dx;
    logic [COORD_BITS-1:0]           dy;
    logic                            xmaj;
    logic                            swap;
    logic [COORD_BITS-1:0]           ax;
    logic [COORD_BITS-1:0]           ay;
    logic [COORD_BITS-1:0]           bx;
    logic [COORD_BITS-1:0]           by;
    lps_pkg::line_kind_t             st_kind;
    logic                            st_dir;
    logic [COORD_BITS-1:0]           st_major;
    logic [COORD_BITS-1:0]           st_minor;
    logic [COORD_BITS-1:0]           st_cx;
    logic [COORD_BITS-1:0]           st_cy;
    logic [COORD_BITS-1:0]           st_sx;
    logic [COORD_BITS-1:0]           st_sy;

    // State the step works from.
    logic                            b_active;
    lps_pkg::line_kind_t             b_kind;
    logic [COORD_BITS-1:0]           b_cx;
    logic [COORD_BITS-1:0]           b_cy;
    logic [COORD_BITS-1:0]           b_sx;
    logic [COORD_BITS-1:0]           b_sy;
    logic [COORD_BITS-1:0]           b_major;
    logic [COORD_BITS-1:0]           b_minor;
    logic [ERR_BITS-1:0]             b_err;
    logic                            b_dir;
    lps_pkg::phase_t                 b_phase;

    // Next state.
    logic                            active_next;
    logic [COORD_BITS-1:0]           cur_x_next;
    logic [COORD_BITS-1:0]           cur_y_next;
    logic [ERR_BITS-1:0]             err_next;
    lps_pkg::phase_t                 phase_next;
    logic [ERR_BITS-1:0]             err_sum;
    logic                            done;

    function automatic logic [COORD_BITS-1:0] step_coord(
        input logic [COORD_BITS-1:0] v,
        input logic                  down
    );
        return down ? v - 1'b1 : v + 1'b1;
    endfunction

    assign is_start = (mode == lps_pkg::MODE_START);

    // Decode the endpoints of a start request.
    always_comb
    begin
        dx   = (x1 < x2) ? x2 - x1 : x1 - x2;
        dy   = (y1 < y2) ? y2 - y1 : y1 - y2;
        xmaj = (dx >= dy);
        swap = xmaj ? (x2 < x1) : (y2 < y1);
        ax   = swap ? x2 : x1;
        ay   = swap ? y2 : y1;
        bx   = swap ? x1 : x2;
        by   = swap ? y1 : y2;
        if (y1 == y2 || x1 == x2)
        begin
            st_kind  = (y1 == y2) ? lps_pkg::KIND_HORIZ : lps_pkg::KIND_VERT;
            st_dir   = (y1 == y2) ? (x2 < x1) : (y2 < y1);
            st_major = '0;
            st_minor = '0;
            st_cx    = x1;
            st_cy    = y1;
            st_sx    = x2;
            st_sy    = y2;
        end
        else
        begin
            st_kind  = xmaj ? lps_pkg::KIND_XMAJOR : lps_pkg::KIND_YMAJOR;
            st_dir   = xmaj ? (by < ay) : (bx < ax);
            st_major = xmaj ? dx : dy;
            st_minor = xmaj ? dy : dx;
            st_cx    = ax;
            st_cy    = ay;
            st_sx    = bx;
            st_sy    = by;
        end
    end

    // A start request replaces the stored line before the step.
    always_comb
    begin
        if (is_start)
        begin
            b_active = 1'b1;
            b_kind   = st_kind;
            b_cx     = st_cx;
            b_cy     = st_cy;
            b_sx     = st_sx;
            b_sy     = st_sy;
            b_major  = st_major;
            b_minor  = st_minor;
            b_err    = '0;
            b_dir    = st_dir;
            b_phase  = lps_pkg::PHASE_MAIN;
        end
        else
        begin
            b_active = active_reg;
            b_kind   = kind_reg;
            b_cx     = cur_x_reg;
            b_cy     = cur_y_reg;
            b_sx     = stop_x_reg;
            b_sy     = stop_y_reg;
            b_major  = major_reg;
            b_minor  = minor_reg;
            b_err    = err_reg;
            b_dir    = dir_reg;
            b_phase  = phase_reg;
        end
    end

    // One step: pick the pixel and advance the walk.
    always_comb
    begin
        emit        = b_active;
        pix_x       = b_cx;
        pix_y       = b_cy;
        pix_last    = 1'b0;
        pix_colour  = is_start ? colour : colour_reg;
        active_next = b_active;
        cur_x_next  = b_cx;
        cur_y_next  = b_cy;
        err_next    = b_err;
        phase_next  = b_phase;
        err_sum     = b_err + ERR_BITS'(b_minor);
        done        = (b_cx == b_sx) && (b_cy == b_sy);

        if (b_kind == lps_pkg::KIND_HORIZ || b_kind == lps_pkg::KIND_VERT)
        begin
            // Straight lines walk one pixel a step up to the end point.
            pix_last = done;
            if (done)
                active_next = 1'b0;
            else if (b_kind == lps_pkg::KIND_HORIZ)
                cur_x_next = step_coord(b_cx, b_dir);
            else
                cur_y_next = step_coord(b_cy, b_dir);
        end
        else if (b_phase == lps_pkg::PHASE_END)
        begin
            // The end point closes the line once more.
            pix_x       = b_sx;
            pix_y       = b_sy;
            pix_last    = 1'b1;
            active_next = 1'b0;
        end
        else
        begin
            if (b_phase == lps_pkg::PHASE_MAIN)
                err_next = err_sum;
            if (b_phase == lps_pkg::PHASE_MAIN && err_sum >= ERR_BITS'(b_major))
            begin
                // Minor step: extra pixel at the same major position.
                err_next   = err_sum - ERR_BITS'(b_major);
                phase_next = lps_pkg::PHASE_MINOR;
                if (b_kind == lps_pkg::KIND_XMAJOR)
                    cur_y_next = step_coord(b_cy, b_dir);
                else
                    cur_x_next = step_coord(b_cx, b_dir);
            end
            else if (b_kind == lps_pkg::KIND_XMAJOR)
            begin
                if (b_cx == b_sx)
                    phase_next = lps_pkg::PHASE_END;
                else
                begin
                    cur_x_next = b_cx + 1'b1;
                    phase_next = lps_pkg::PHASE_MAIN;
                end
            end
            else
            begin
                if (b_cy == b_sy)
                    phase_next = lps_pkg::PHASE_END;
                else
                begin
                    cur_y_next = b_cy + 1'b1;
                    phase_next = lps_pkg::PHASE_MAIN;
                end
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            kind_reg   <= lps_pkg::KIND_HORIZ;
            phase_reg  <= lps_pkg::PHASE_MAIN;
        end
        else if (load && emit)
        begin
            active_reg <= active_next;
            kind_reg   <= b_kind;
            phase_reg  <= phase_next;
        end
    end

    // Line geometry and colour.
    always_ff @(posedge clk)
    begin
        if (load && emit)
        begin
            cur_x_reg  <= cur_x_next;
            cur_y_reg  <= cur_y_next;
            stop_x_reg <= b_sx;
            stop_y_reg <= b_sy;
            major_reg  <= b_major;
            minor_reg  <= b_minor;
            err_reg    <= err_next;
            dir_reg    <= b_dir;
        end
        if (load && is_start)
            colour_reg <= colour;
    end

endmodule

// ===== hdl/line_pixel_stepper.sv =====
// ----------------------------------------------------------------------------
// Line pixel stepper
// Rasterizes a line into framebuffer pixel writes, one pixel per request.
// ----------------------------------------------------------------------------
// Usage:
// A request on the s_axis channel with tuser low starts a line from its two
// endpoints and colour and yields the first pixel; a request with tuser high
// yields the next pixel. A step request with no line active is taken and
// yields nothing. Results leave on m_axis with tlast set on the last pixel.
// The line state is updated as a request is taken, so requests may follow
// each other in every cycle: throughput is one pixel per clock while m_axis
// takes the pixels. The first register holds the pixel coordinates, the
// second the finished write after the row-times-width multiply for the
// address. When m_axis stalls, the two stages fill and then s_axis_tready
// drops. Reset clears all valid flags and the active line, and sets the row
// length to 800. The user must write frame_width through frame_width_we
// only while idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module line_pixel_stepper #(
    parameter int COORD_BITS = 12
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Row length register.
    input  logic                          frame_width_we,
    input  logic [lps_pkg::FW_BITS-1:0]   frame_width_wdata,
    // Requests.
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // x_start[11:0], y_start[23:12], x_end[35:24], y_end[47:36], colour[79:48]
    input  logic [79:0]                   s_axis_tdata,
    // mode[0]
    input  logic                          s_axis_tuser,
    // Pixel writes.
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // pixel_x[11:0], pixel_y[23:12], pixel_address[47:24], pixel_value[79:48]
    output logic [79:0]                   m_axis_tdata,
    // last_pixel
    output logic                          m_axis_tlast
);

    localparam int PROD_BITS = COORD_BITS + lps_pkg::FW_BITS;

    logic [lps_pkg::FW_BITS-1:0]      frame_width_reg;

    logic                             s_accept;
    logic                             out_load;

    logic                             emit;
    logic [COORD_BITS-1:0]            pix_x;
    logic [COORD_BITS-1:0]            pix_y;
    logic                             pix_last;
    logic [lps_pkg::COLOUR_BITS-1:0]  pix_colour;

    // Coordinate stage.
    logic                             s1_valid_reg;
    logic [COORD_BITS-1:0]            s1_x_reg;
    logic [COORD_BITS-1:0]            s1_y_reg;
    logic                             s1_last_reg;
    logic [lps_pkg::COLOUR_BITS-1:0]  s1_colour_reg;

    // Output stage.
    logic                             out_valid_reg;
    logic [lps_pkg::PIX_BITS-1:0]     out_x_reg;
    logic [lps_pkg::PIX_BITS-1:0]     out_y_reg;
    logic [lps_pkg::ADDR_BITS-1:0]    out_addr_reg;
    logic [lps_pkg::COLOUR_BITS-1:0]  out_colour_reg;
    logic                             out_last_reg;

    logic [PROD_BITS-1:0]             addr_full;

    // Handshake: the output register frees up when empty or taken.
    assign out_load      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !s1_valid_reg || out_load;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    // Row length register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            frame_width_reg <= lps_pkg::FW_RESET;
        else if (frame_width_we)
            frame_width_reg <= frame_width_wdata;
    end

    lps_core #(
        .COORD_BITS (COORD_BITS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (s_accept),
        .mode       (s_axis_tuser),
        .x1         (COORD_BITS'(s_axis_tdata[11:0])),
        .y1         (COORD_BITS'(s_axis_tdata[23:12])),
        .x2         (COORD_BITS'(s_axis_tdata[35:24])),
        .y2         (COORD_BITS'(s_axis_tdata[47:36])),
        .colour     (s_axis_tdata[79:48]),
        .emit       (emit),
        .pix_x      (pix_x),
        .pix_y      (pix_y),
        .pix_last   (pix_last),
        .pix_colour (pix_colour)
    );

    // Coordinate stage valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s_accept)
            s1_valid_reg <= emit;
        else if (out_load)
            s1_valid_reg <= 1'b0;
    end

    // Coordinate stage payload.
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_x_reg      <= pix_x;
            s1_y_reg      <= pix_y;
            s1_last_reg   <= pix_last;
            s1_colour_reg <= pix_colour;
        end
    end

    // Address is row times width plus column, kept to the low 24 bits.
    assign addr_full = PROD_BITS'(s1_y_reg) * PROD_BITS'(frame_width_reg)
                     + PROD_BITS'(s1_x_reg);

    // Output stage valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= s1_valid_reg;
    end

    // Output stage payload.
    always_ff @(posedge clk)
    begin
        if (out_load && s1_valid_reg)
        begin
            out_x_reg      <= lps_pkg::PIX_BITS'(s1_x_reg);
            out_y_reg      <= lps_pkg::PIX_BITS'(s1_y_reg);
            out_addr_reg   <= lps_pkg::ADDR_BITS'(addr_full);
            out_colour_reg <= s1_colour_reg;
            out_last_reg   <= s1_last_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_colour_reg, out_addr_reg, out_y_reg, out_x_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

// ===== verif/tb_line_pixel_stepper.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Line pixel stepper testbench
// Drives start and step requests into the line rasterizer and checks every
// pixel write against a cycle-free model of the line walk. A short directed
// part covers points, straight lines, diagonal overshoot with coordinate
// wrap, an interrupted line and steps with no line open. Random lines with
// random stalls on both sides follow, under several row lengths.
// ----------------------------------------------------------------------------

// One expected pixel write.
typedef struct packed {
    logic [lps_pkg::PIX_BITS-1:0]    x;
    logic [lps_pkg::PIX_BITS-1:0]    y;
    logic [lps_pkg::ADDR_BITS-1:0]   addr;
    logic [lps_pkg::COLOUR_BITS-1:0] value;
    logic                            last;
} pixel_write_t;

// Walks the current line one pixel per request and holds the pixel writes
// that the block still owes.
class pixel_write_check;
    logic [lps_pkg::FW_BITS-1:0]     row_len;
    bit                              line_on;
    lps_pkg::line_kind_t             kind;
    lps_pkg::phase_t                 step_phase;
    logic [lps_pkg::PIX_BITS-1:0]    px;
    logic [lps_pkg::PIX_BITS-1:0]    py;
    logic [lps_pkg::PIX_BITS-1:0]    end_x;
    logic [lps_pkg::PIX_BITS-1:0]    end_y;
    logic [lps_pkg::PIX_BITS-1:0]    major_span;
    logic [lps_pkg::PIX_BITS-1:0]    minor_span;
    logic [12:0]                     err_acc;
    bit                              step_down;
    logic [lps_pkg::COLOUR_BITS-1:0] ink;
    pixel_write_t                    due_pixels[$];
    int                              errors;

    function new();
        row_len    = lps_pkg::FW_RESET;
        line_on    = 1'b0;
        kind       = lps_pkg::KIND_HORIZ;
        step_phase = lps_pkg::PHASE_MAIN;
        px         = '0;
        py         = '0;
        end_x      = '0;
        end_y      = '0;
        major_span = '0;
        minor_span = '0;
        err_acc    = '0;
        step_down  = 1'b0;
        ink        = '0;
        errors     = 0;
    endfunction

    function logic [lps_pkg::PIX_BITS-1:0] walk(input logic [lps_pkg::PIX_BITS-1:0] v,
                                                input bit down);
        return down ? v - 1'b1 : v + 1'b1;
    endfunction

    // The address is formed at 24 bits, so it wraps like the block.
    function void emit(input logic [lps_pkg::PIX_BITS-1:0] x,
                       input logic [lps_pkg::PIX_BITS-1:0] y, input bit last);
        pixel_write_t p;
        p.x     = x;
        p.y     = y;
        p.addr  = lps_pkg::ADDR_BITS'(y) * lps_pkg::ADDR_BITS'(row_len)
                + lps_pkg::ADDR_BITS'(x);
        p.value = ink;
        p.last  = last;
        due_pixels.push_back(p);
    endfunction

    // Move to the next major position, or to the closing end pixel.
    function void advance_major();
        if (kind == lps_pkg::KIND_XMAJOR)
        begin
            if (px == end_x)
                step_phase = lps_pkg::PHASE_END;
            else
            begin
                px = px + 1'b1;
                step_phase = lps_pkg::PHASE_MAIN;
            end
        end
        else
        begin
            if (py == end_y)
                step_phase = lps_pkg::PHASE_END;
            else
            begin
                py = py + 1'b1;
                step_phase = lps_pkg::PHASE_MAIN;
            end
        end
    endfunction

    function void walk_line_pixel();
        bit at_end;
        if (kind == lps_pkg::KIND_HORIZ || kind == lps_pkg::KIND_VERT)
        begin
            at_end = (px == end_x) && (py == end_y);
            emit(px, py, at_end);
            if (at_end)
                line_on = 1'b0;
            else if (kind == lps_pkg::KIND_HORIZ)
                px = walk(px, step_down);
            else
                py = walk(py, step_down);
        end
        else if (step_phase == lps_pkg::PHASE_END)
        begin
            emit(end_x, end_y, 1'b1);
            line_on = 1'b0;
        end
        else
        begin
            emit(px, py, 1'b0);
            if (step_phase == lps_pkg::PHASE_MINOR)
                advance_major();
            else
            begin
                // Error term reaching the major span takes a minor step with
                // an extra pixel at the same major position.
                err_acc = err_acc + 13'(minor_span);
                if (err_acc >= 13'(major_span))
                begin
                    err_acc = err_acc - 13'(major_span);
                    if (kind == lps_pkg::KIND_XMAJOR)
                        py = walk(py, step_down);
                    else
                        px = walk(px, step_down);
                    step_phase = lps_pkg::PHASE_MINOR;
                end
                else
                    advance_major();
            end
        end
    endfunction

    // Returns 1 when the request does something, 0 for a step with no line.
    function bit note_request(input logic mode, input logic [79:0] data);
        logic [lps_pkg::PIX_BITS-1:0] x0, y0, x1, y1, dx, dy, t;
        bit                           x_major;
        if (mode == lps_pkg::MODE_STEP)
        begin
            if (!line_on)
                return 1'b0;
            walk_line_pixel();
            return 1'b1;
        end
        x0  = data[11:0];
        y0  = data[23:12];
        x1  = data[35:24];
        y1  = data[47:36];
        ink = data[79:48];
        dx  = (x0 < x1) ? x1 - x0 : x0 - x1;
        dy  = (y0 < y1) ? y1 - y0 : y0 - y1;
        err_acc    = '0;
        step_phase = lps_pkg::PHASE_MAIN;
        if (y0 == y1 || x0 == x1)
        begin
            kind       = (y0 == y1) ? lps_pkg::KIND_HORIZ : lps_pkg::KIND_VERT;
            step_down  = (kind == lps_pkg::KIND_HORIZ) ? (x1 < x0) : (y1 < y0);
            major_span = '0;
            minor_span = '0;
        end
        else
        begin
            // Order the endpoints so that the major coordinate rises.
            x_major = (dx >= dy);
            if (x_major ? (x1 < x0) : (y1 < y0))
            begin
                t = x0; x0 = x1; x1 = t;
                t = y0; y0 = y1; y1 = t;
            end
            kind       = x_major ? lps_pkg::KIND_XMAJOR : lps_pkg::KIND_YMAJOR;
            major_span = x_major ? dx : dy;
            minor_span = x_major ? dy : dx;
            step_down  = x_major ? (y1 < y0) : (x1 < x0);
        end
        px      = x0;
        py      = y0;
        end_x   = x1;
        end_y   = y1;
        line_on = 1'b1;
        walk_line_pixel();
        return 1'b1;
    endfunction

    function void compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endfunction

    function void check_pixel(input logic [79:0] data, input logic last);
        pixel_write_t want;
        if (due_pixels.size() == 0)
        begin
            $error("pixel write at x=%0d y=%0d with none expected", data[11:0], data[23:12]);
            errors++;
            return;
        end
        want = due_pixels.pop_front();
        compare_field("pixel_x", 32'(want.x), 32'(data[11:0]));
        compare_field("pixel_y", 32'(want.y), 32'(data[23:12]));
        compare_field("pixel_address", 32'(want.addr), 32'(data[47:24]));
        compare_field("pixel_value", want.value, data[79:48]);
        compare_field("last_pixel", 32'(want.last), 32'(last));
    endfunction
endclass

module tb_line_pixel_stepper;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RX_HOLD_AT  = 150;
    localparam int RX_HOLD_LEN = 400;
    localparam logic [lps_pkg::PIX_BITS-1:0] COORD_MAX = 12'hFFF;

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         frame_width_we;
    logic [lps_pkg::FW_BITS-1:0]  frame_width_wdata;
    logic                         s_axis_tvalid;
    logic                         s_axis_tready;
    logic [79:0]                  s_axis_tdata;
    logic                         s_axis_tuser;
    logic                         m_axis_tvalid;
    logic                         m_axis_tready;
    logic [79:0]                  m_axis_tdata;
    logic                         m_axis_tlast;

    pixel_write_check    board = new();
    int                  tx_sent  = 0;
    int                  tx_items = 0;
    bit                  tx_quiet = 1'b0;
    int                  rx_count = 0;
    bit                  rx_quiet = 1'b0;
    int                  cycle_count = 0;

    line_pixel_stepper dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .frame_width_we    (frame_width_we),
        .frame_width_wdata (frame_width_wdata),
        .s_axis_tvalid     (s_axis_tvalid),
        .s_axis_tready     (s_axis_tready),
        .s_axis_tdata      (s_axis_tdata),
        .s_axis_tuser      (s_axis_tuser),
        .m_axis_tvalid     (m_axis_tvalid),
        .m_axis_tready     (m_axis_tready),
        .m_axis_tdata      (m_axis_tdata),
        .m_axis_tlast      (m_axis_tlast)
    );

    // 10 ns clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_line_pixel_stepper NOT OK");
            $finish;
        end
    end

    function automatic logic [79:0] line_payload(
        input logic [lps_pkg::PIX_BITS-1:0] x0, y0, x1, y1,
        input logic [31:0] c
    );
        return {c, y1, x1, y0, x0};
    endfunction

    // Step requests carry ignored data; keep it random.
    function automatic logic [79:0] random_payload();
        return {16'($urandom), $urandom, $urandom};
    endfunction

    function automatic logic [lps_pkg::PIX_BITS-1:0] nearby_coord(
        input logic [lps_pkg::PIX_BITS-1:0] v,
        input int span
    );
        int lo;
        int hi;
        lo = (v > span) ? v - span : 0;
        hi = (v + span > COORD_MAX) ? COORD_MAX : v + span;
        return lps_pkg::PIX_BITS'($urandom_range(lo, hi));
    endfunction

    // Offset by exactly d in a random direction, staying inside the frame.
    function automatic logic [lps_pkg::PIX_BITS-1:0] diag_coord(
        input logic [lps_pkg::PIX_BITS-1:0] v,
        input int d
    );
        bit down;
        down = 1'($urandom_range(0, 1));
        if (down ? (v >= d) : (v + d <= COORD_MAX))
            return lps_pkg::PIX_BITS'(down ? v - d : v + d);
        return lps_pkg::PIX_BITS'(down ? v + d : v - d);
    endfunction

    // Offer one request after a random gap and wait for it to be taken.
    task automatic send_request(input logic mode, input logic [79:0] data);
        int gap;
        if (tx_sent % 48 == 0)
            tx_quiet = ($urandom_range(0, 2) == 0);
        tx_sent++;
        gap = tx_quiet ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= data;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (board.note_request(mode, data))
            tx_items++;
    endtask

    // Start a line and step it until it finishes or max_steps run out.
    task automatic draw_line(input logic [lps_pkg::PIX_BITS-1:0] x0, y0, x1, y1,
                             input logic [31:0] c, input int max_steps);
        int steps;
        steps = 0;
        send_request(lps_pkg::MODE_START, line_payload(x0, y0, x1, y1, c));
        while (board.line_on && steps < max_steps)
        begin
            send_request(lps_pkg::MODE_STEP, random_payload());
            steps++;
        end
    endtask

    // Stop offering, wait for every owed pixel, then let the pipeline settle.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (board.due_pixels.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_width(input logic [lps_pkg::FW_BITS-1:0] w);
        frame_width_wdata <= w;
        frame_width_we    <= 1'b1;
        @(posedge clk);
        frame_width_we    <= 1'b0;
        board.row_len = w;
    endtask

    task automatic run_directed();
        // Step with no line open, then a y-major line cut short by a new start.
        send_request(lps_pkg::MODE_STEP, random_payload());
        draw_line(12'd10, 12'd20, 12'd12, 12'd27, $urandom, 2);
        draw_line(12'd0, 12'd0, 12'd0, 12'd0, 32'h0000_0000, 100);
        draw_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 32'hFFFF_FFFF, 100);
        // Horizontal right to left, vertical upward at the frame edge.
        draw_line(12'd3, 12'd5, 12'd0, 12'd5, $urandom, 100);
        draw_line(COORD_MAX, 12'd4094, COORD_MAX, COORD_MAX, $urandom, 100);
        // Equal deltas: the minor coordinate overshoots and wraps both ways.
        draw_line(12'd0, 12'd4094, 12'd1, COORD_MAX, $urandom, 100);
        draw_line(12'd0, 12'd1, 12'd1, 12'd0, $urandom, 100);
        // Step after the last pixel.
        send_request(lps_pkg::MODE_STEP, random_payload());
    endtask

    task automatic run_random(input int count);
        int                           stop_at;
        int                           shape;
        int                           max_steps;
        int                           d;
        logic [lps_pkg::PIX_BITS-1:0] x0, y0, x1, y1;
        stop_at = tx_items + count;
        while (tx_items < stop_at)
        begin
            if ($urandom_range(0, 99) < 6)
                send_request(lps_pkg::MODE_STEP, random_payload());
            else
            begin
                x0 = lps_pkg::PIX_BITS'($urandom_range(0, COORD_MAX));
                y0 = lps_pkg::PIX_BITS'($urandom_range(0, COORD_MAX));
                max_steps = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 6) : 100000;
                shape = $urandom_range(0, 9);
                case (shape)
                    0:
                    begin
                        x1 = x0;
                        y1 = y0;
                    end
                    1:
                    begin
                        x1 = nearby_coord(x0, 20);
                        y1 = y0;
                    end
                    2:
                    begin
                        x1 = x0;
                        y1 = nearby_coord(y0, 20);
                    end
                    3:
                    begin
                        d  = $urandom_range(1, 12);
                        x1 = diag_coord(x0, d);
                        y1 = diag_coord(y0, d);
                    end
                    4:
                    begin
                        // Line to any point in the frame, given a short step limit.
                        x1 = lps_pkg::PIX_BITS'($urandom_range(0, COORD_MAX));
                        y1 = lps_pkg::PIX_BITS'($urandom_range(0, COORD_MAX));
                        max_steps = $urandom_range(2, 40);
                    end
                    default:
                    begin
                        x1 = nearby_coord(x0, 24);
                        y1 = nearby_coord(y0, 24);
                    end
                endcase
                draw_line(x0, y0, x1, y1, $urandom, max_steps);
            end
        end
    endtask

    // Pixel receiver with random stalls and one long hold-off.
    initial
    begin
        int stall;
        m_axis_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        m_axis_tready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (m_axis_tready && m_axis_tvalid)
            begin
                board.check_pixel(m_axis_tdata, m_axis_tlast);
                if (rx_count % 64 == 0)
                    rx_quiet = ($urandom_range(0, 2) == 0);
                rx_count++;
                stall = rx_quiet ? 0 : $urandom_range(0, 13);
                if (rx_count == RX_HOLD_AT)
                    stall = RX_HOLD_LEN;
                if (stall > 0)
                begin
                    m_axis_tready <= 1'b0;
                    repeat (stall) @(posedge clk);
                    m_axis_tready <= 1'b1;
                end
            end
        end
    end

    // Reset, then the directed part and three random phases under
    // different row lengths.
    initial
    begin
        rst_n             = 1'b0;
        frame_width_we    = 1'b0;
        frame_width_wdata = '0;
        s_axis_tvalid     = 1'b0;
        s_axis_tdata      = '0;
        s_axis_tuser      = lps_pkg::MODE_STEP;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        drain();
        write_width(13'd1);
        run_random(210);
        drain();
        write_width(13'd4096);
        run_random(210);
        drain();
        write_width(lps_pkg::FW_BITS'($urandom_range(2, 4095)));
        run_random(210);
        drain();
        repeat (20) @(posedge clk);

        if (board.errors == 0)
            $display("tb_line_pixel_stepper OK");
        else
            $display("tb_line_pixel_stepper NOT OK");
        $finish;
    end

endmodule
